@@ hw/rtl/slic_pkg.sv @@
// Shared types and constants of the sorted list intersection counter.
package slic_pkg;

  // Fixed field widths of the input and result channels.
  localparam int KIND_W    = 2;
  localparam int ADDR_IN_W = 8;
  localparam int VALUE_IN_W = 32;
  localparam int BOUND_W   = 9;
  localparam int COUNT_W   = 9;

  // Defaults for the top-level parameters.
  localparam int LIST_DEPTH_DEF = 256;
  localparam int VALUE_BITS_DEF = 32;

  // The match count saturates at this value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Item kinds carried on the kind field; the fourth code is unused.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

endpackage

@@ hw/rtl/slic_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module slic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/sorted_list_intersection_count_top.sv @@
// Top level of the sorted list intersection counter: list storage and merge sequencer.
//
//   Channel   Ports                                   Transfer
//   --------  --------------------------------------  ----------------------------------
//   input     start, busy, in_kind, in_addr,          at a rising edge with start high
//             in_value, in_a_low, in_b_low,           and busy low
//             in_a_high, in_b_high
//   result    out_valid, out_match_count              at the rising edge that ends the
//                                                     single cycle out_valid is high
//
// A load item (write of one list A or list B entry) leaves busy low, and the next item
// may follow in the next cycle. The two window heads of a start item are fetched at
// its transfer edge. Busy then stays high through the merge steps and one final check
// that finds a window used up, where the number of steps is at most the sum of the two
// window lengths; out_valid rises at the same edge at which busy falls. The pace of
// the merge is set by the read port of each list memory, which delivers one head per
// cycle. Reset is synchronous and active low; it clears the sequencer and the result
// strobe but not the list contents.
// The receiver cannot stall the result channel, so each count is shown only once.
module sorted_list_intersection_count_top #(
  parameter int LIST_DEPTH = slic_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = slic_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [slic_pkg::KIND_W-1:0]       in_kind,
  input  logic [slic_pkg::ADDR_IN_W-1:0]    in_addr,
  input  logic [slic_pkg::VALUE_IN_W-1:0]   in_value,
  input  logic [slic_pkg::BOUND_W-1:0]      in_a_low,
  input  logic [slic_pkg::BOUND_W-1:0]      in_b_low,
  input  logic [slic_pkg::BOUND_W-1:0]      in_a_high,
  input  logic [slic_pkg::BOUND_W-1:0]      in_b_high,
  output logic                              out_valid,
  output logic [slic_pkg::COUNT_W-1:0]      out_match_count
);

  import slic_pkg::*;

  localparam int AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [31:0] DepthW = 32'(LIST_DEPTH);
  // The pointers carry one spare bit, so a window that ends at the largest bound
  // value still stops instead of wrapping back to zero.
  localparam int PtrW = BOUND_W + 1;

  // A bound above the list depth is pulled down to the depth. When the depth is
  // above the largest bound value the compare never fires.
  function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
    logic [BOUND_W-1:0] r;
    r = b;
    if (32'(b) > DepthW) begin
      r = BOUND_W'(DepthW);
    end
    return r;
  endfunction

  // Sequencer state and merge registers.
  state_t               state_r, state_nxt;
  logic [PtrW-1:0]      ptr_a_r, ptr_a_nxt;
  logic [PtrW-1:0]      ptr_b_r, ptr_b_nxt;
  logic [BOUND_W-1:0]   high_a_r, high_a_nxt;
  logic [BOUND_W-1:0]   high_b_r, high_b_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  // Memory ports.
  logic                  we_a, we_b;
  logic                  addr_ok;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] head_a, head_b;
  logic                  accept;
  logic                  step_ok;

  assign accept  = start && (state_r == ST_IDLE);
  assign addr_ok = (32'(in_addr) < DepthW);
  assign wdata   = VALUE_BITS'(in_value);
  assign we_a    = accept && (in_kind == KIND_LOAD_A) && addr_ok;
  assign we_b    = accept && (in_kind == KIND_LOAD_B) && addr_ok;

  // A merge step is possible while both windows still hold an entry.
  assign step_ok = (ptr_a_r < PtrW'(high_a_r)) && (ptr_b_r < PtrW'(high_b_r));

  // The memories are read every cycle at the next pointer values, so the heads
  // for the current pointers are present in the RUN state. Writes are taken only
  // while idle, so no list entry is written while a merge reads it.
  slic_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (AddrW'(in_addr)),
    .wdata (wdata),
    .raddr (AddrW'(ptr_a_nxt)),
    .rdata (head_a)
  );

  slic_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (AddrW'(in_addr)),
    .wdata (wdata),
    .raddr (AddrW'(ptr_b_nxt)),
    .rdata (head_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_a_r     <= ptr_a_nxt;
    ptr_b_r     <= ptr_b_nxt;
    high_a_r    <= high_a_nxt;
    high_b_r    <= high_b_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_a_nxt     = ptr_a_r;
    ptr_b_nxt     = ptr_b_r;
    high_a_nxt    = high_a_r;
    high_b_nxt    = high_b_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_START)) begin
          ptr_a_nxt  = PtrW'(clamp_bound(in_a_low));
          ptr_b_nxt  = PtrW'(clamp_bound(in_b_low));
          high_a_nxt = clamp_bound(in_a_high);
          high_b_nxt = clamp_bound(in_b_high);
          count_nxt  = '0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_ok) begin
          if (head_a == head_b) begin
            ptr_a_nxt = ptr_a_r + 1'b1;
            ptr_b_nxt = ptr_b_r + 1'b1;
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (head_a < head_b) begin
            ptr_a_nxt = ptr_a_r + 1'b1;
          end else begin
            ptr_b_nxt = ptr_b_r + 1'b1;
          end
        end else begin
          // One window is used up: the count is final.
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r == ST_RUN);
  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;

  // A result only follows a cycle of merging.
  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RUN))
    else $error("result strobe without a preceding merge");

  // Every merge step advances at least one pointer.
  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_ok) |=>
      (ptr_a_r != $past(ptr_a_r) || ptr_b_r != $past(ptr_b_r)))
    else $error("merge step did not advance a pointer");

  // Pointers never move backward during a merge.
  a_ptr_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && $past(state_r == ST_RUN)) |->
      (ptr_a_r >= $past(ptr_a_r) && ptr_b_r >= $past(ptr_b_r)))
    else $error("merge pointer moved backward");

  // The lists are never written while a merge reads them.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!we_a && !we_b))
    else $error("list write during a merge");

endmodule
